@@ sv/fixed_point_q24_8_alu_assert.svh @@
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// implication checked in the same cycle
`define FPA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpa check failed");

// implication whose consequent is checked after the delay n
`define FPA_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("fpa check failed");

// condition that must hold on every cycle, reset included
`define FPA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) (cond)) \
    else $error("fpa check failed");

`endif

@@ sv/fpa_pkg.sv @@
package fpa_pkg;

  localparam int WORD_W   = 32;
  localparam int FRAC_W   = 8;
  localparam int TOL_W    = 8;
  localparam int DIV_W    = WORD_W + FRAC_W;
  localparam int PIPE_LAT = DIV_W + 5;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_NEG   = 4'd4,
    OP_INC   = 4'd5,
    OP_DEC   = 4'd6,
    OP_EQ    = 4'd7,
    OP_NE    = 4'd8,
    OP_GT    = 4'd9,
    OP_LT    = 4'd10,
    OP_GE    = 4'd11,
    OP_LE    = 4'd12,
    OP_MAX   = 4'd13,
    OP_MIN   = 4'd14,
    OP_ROUND = 4'd15
  } op_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [WORD_W-1:0]  operand_a;
    logic signed [WORD_W-1:0]  operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  result_value;
    logic                      compare_true;
    logic                      divide_by_zero;
    logic                      overflow;
  } fpa_out_t;

endpackage

@@ sv/fixed_point_q24_8_alu.sv @@
// each item passes stages a, b, c and d, the divider chain and the done register
// throughput: one item per cycle, busy is never raised
// the divider runs one quotient bit per stage over 40 stages, which sets latency
// reset clears all valid bits and sets the tolerance to one; items in flight are dropped
// the receiver cannot stall, each result shows for exactly one cycle
module fixed_point_q24_8_alu (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  fpa_pkg::fpa_in_t cmd,
  input  logic             tolerance_we,
  input  logic [7:0]       tolerance_wdata,
  output logic             done,
  output fpa_pkg::fpa_out_t result
);
  import fpa_pkg::*;

  `include "fixed_point_q24_8_alu_assert.svh"

  // divider pipeline stage, also carries the finished result of other ops
  typedef struct packed {
    logic              valid;
    op_t               op;
    fpa_out_t          res;
    logic              neg;
    logic [WORD_W-1:0] mb;
    logic [DIV_W-1:0]  n;
    logic [WORD_W-1:0] r;
    logic [DIV_W-1:0]  q;
  } div_stage_t;

  // saturate a sign-magnitude value into the word, overflow flag on top
  function automatic logic [WORD_W:0] sat_pack(input logic neg, input logic [63:0] mag);
    logic [63:0]       limit;
    logic [63:0]       m;
    logic              ov;
    logic [WORD_W-1:0] v;
    limit = neg ? (64'd1 << (WORD_W - 1)) : ((64'd1 << (WORD_W - 1)) - 64'd1);
    ov    = mag > limit;
    m     = ov ? limit : mag;
    v     = neg ? (WORD_W'(0) - m[WORD_W-1:0]) : m[WORD_W-1:0];
    return {ov, v};
  endfunction

  // pack a 33-bit two's complement sum
  function automatic logic [WORD_W:0] sat_sum(input logic [WORD_W:0] x);
    logic [WORD_W:0] mag;
    mag = x[WORD_W] ? ((WORD_W+1)'(0) - x) : x;
    return sat_pack(x[WORD_W], 64'(mag));
  endfunction

  // one restoring division step
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t      o;
    logic [WORD_W:0] rs;
    o    = s;
    rs   = {s.r, s.n[DIV_W-1]};
    o.n  = {s.n[DIV_W-2:0], 1'b0};
    if (rs >= {1'b0, s.mb}) begin
      o.r = WORD_W'(rs - {1'b0, s.mb});
      o.q = {s.q[DIV_W-2:0], 1'b1};
    end else begin
      o.r = rs[WORD_W-1:0];
      o.q = {s.q[DIV_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [TOL_W-1:0] tol;

  // stage a: input register
  logic    a_valid;
  fpa_in_t a_cmd;

  // stage b: magnitudes and exact sums
  logic              b_valid;
  op_t               b_op;
  logic [WORD_W-1:0] b_a;
  logic [WORD_W-1:0] b_b;
  logic              b_na;
  logic              b_nb;
  logic [WORD_W-1:0] b_ma;
  logic [WORD_W-1:0] b_mb;
  logic [WORD_W:0]   b_sum;
  logic [WORD_W:0]   b_diff;
  logic [WORD_W:0]   b_inc;
  logic [WORD_W:0]   b_dec;
  logic              b_dz;

  // stage c: product and simple results
  logic              c_valid;
  op_t               c_op;
  fpa_out_t          c_res;
  fpa_out_t          c_res_next;
  logic [63:0]       c_prod;
  logic              c_neg;
  logic [WORD_W-1:0] c_ma;
  logic [WORD_W-1:0] c_mb;

  div_stage_t d_stage;
  div_stage_t d_stage_next;
  div_stage_t dv [DIV_W];
  div_stage_t dv_next [DIV_W];

  logic              done_next;
  fpa_out_t          result_next;

  // tolerance comparisons, worked on stage b values
  logic [WORD_W:0] diff_mag;
  logic            in_band;
  logic            gt;
  logic            lt;
  logic [WORD_W:0] rnd_mag;
  logic [WORD_W:0] pk;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_W'(1);
    end else if (tolerance_we) begin
      tol <= tolerance_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
    a_cmd <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_op   <= a_cmd.operation;
    b_a    <= a_cmd.operand_a;
    b_b    <= a_cmd.operand_b;
    b_na   <= a_cmd.operand_a[WORD_W-1];
    b_nb   <= a_cmd.operand_b[WORD_W-1];
    b_ma   <= a_cmd.operand_a[WORD_W-1] ? (WORD_W'(0) - a_cmd.operand_a) : a_cmd.operand_a;
    b_mb   <= a_cmd.operand_b[WORD_W-1] ? (WORD_W'(0) - a_cmd.operand_b) : a_cmd.operand_b;
    b_sum  <= {a_cmd.operand_a[WORD_W-1], a_cmd.operand_a}
              + {a_cmd.operand_b[WORD_W-1], a_cmd.operand_b};
    b_diff <= {a_cmd.operand_a[WORD_W-1], a_cmd.operand_a}
              - {a_cmd.operand_b[WORD_W-1], a_cmd.operand_b};
    b_inc  <= {a_cmd.operand_a[WORD_W-1], a_cmd.operand_a} + (WORD_W+1)'(tol);
    b_dec  <= {a_cmd.operand_a[WORD_W-1], a_cmd.operand_a} - (WORD_W+1)'(tol);
    b_dz   <= (a_cmd.operand_b[WORD_W-1] ? (WORD_W'(0) - a_cmd.operand_b)
                                         : a_cmd.operand_b) <= WORD_W'(tol);
  end

  always_comb begin
    diff_mag   = b_diff[WORD_W] ? ((WORD_W+1)'(0) - b_diff) : b_diff;
    in_band    = diff_mag <= (WORD_W+1)'(tol);
    gt         = !in_band && !b_diff[WORD_W];
    lt         = !in_band && b_diff[WORD_W];
    // round to integer: magnitude plus half, then drop the fraction
    rnd_mag    = ({1'b0, b_ma} + (WORD_W+1)'(1 << (FRAC_W - 1))) >> FRAC_W;
    c_res_next = '0;
    pk         = '0;
    unique case (b_op)
      OP_ADD: pk = sat_sum(b_sum);
      OP_SUB: pk = sat_sum(b_diff);
      OP_INC: pk = sat_sum(b_inc);
      OP_DEC: pk = sat_sum(b_dec);
      OP_NEG: pk = sat_pack(!b_na, 64'(b_ma));
      default: pk = '0;
    endcase
    unique case (b_op)
      OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_NEG: begin
        c_res_next.result_value = pk[WORD_W-1:0];
        c_res_next.overflow     = pk[WORD_W];
      end
      OP_MUL: c_res_next = '0;
      // divisor near zero hands back the first operand
      OP_DIV: begin
        if (b_dz) begin
          c_res_next.result_value = b_a;
          c_res_next.divide_by_zero = 1'b1;
        end
      end
      OP_EQ: c_res_next.compare_true = in_band;
      OP_NE: c_res_next.compare_true = !in_band;
      OP_GT: c_res_next.compare_true = gt;
      OP_LT: c_res_next.compare_true = lt;
      OP_GE: c_res_next.compare_true = in_band || gt;
      OP_LE: c_res_next.compare_true = in_band || lt;
      OP_MAX: c_res_next.result_value = (in_band || gt) ? b_a : b_b;
      OP_MIN: c_res_next.result_value = (in_band || lt) ? b_a : b_b;
      OP_ROUND: begin
        c_res_next.result_value = b_na ? (WORD_W'(0) - rnd_mag[WORD_W-1:0])
                                       : rnd_mag[WORD_W-1:0];
      end
      default: c_res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_op   <= b_op;
    c_res  <= c_res_next;
    c_prod <= 64'(b_ma) * 64'(b_mb);
    c_neg  <= b_na ^ b_nb;
    c_ma   <= b_ma;
    c_mb   <= b_mb;
  end

  // stage d: product rounding and divider setup
  always_comb begin
    logic [63:0] mq;
    mq                 = (c_prod + 64'(1 << (FRAC_W - 1))) >> FRAC_W;
    d_stage_next       = '0;
    d_stage_next.valid = c_valid;
    d_stage_next.op    = c_op;
    d_stage_next.res   = c_res;
    d_stage_next.neg   = c_neg;
    d_stage_next.mb    = c_mb;
    d_stage_next.n     = {c_ma, FRAC_W'(0)};
    if (c_op == OP_MUL) begin
      {d_stage_next.res.overflow, d_stage_next.res.result_value} = sat_pack(c_neg, mq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_stage.valid <= 1'b0;
    end else begin
      d_stage.valid <= d_stage_next.valid;
    end
    d_stage.op  <= d_stage_next.op;
    d_stage.res <= d_stage_next.res;
    d_stage.neg <= d_stage_next.neg;
    d_stage.mb  <= d_stage_next.mb;
    d_stage.n   <= d_stage_next.n;
    d_stage.r   <= '0;
    d_stage.q   <= '0;
  end

  // divider chain, one quotient bit per stage
  always_comb begin
    dv_next[0] = div_step(d_stage);
    for (int k = 1; k < DIV_W; k++) begin
      dv_next[k] = div_step(dv[k-1]);
    end
    if (rst) begin
      for (int k = 0; k < DIV_W; k++) begin
        dv_next[k].valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dv <= dv_next;
  end

  // final rounding of the quotient, half away from zero
  always_comb begin
    logic [DIV_W:0]  qr;
    logic [WORD_W:0] dp;
    qr          = {1'b0, dv[DIV_W-1].q}
                  + (DIV_W+1)'({dv[DIV_W-1].r, 1'b0} >= {1'b0, dv[DIV_W-1].mb});
    result_next = dv[DIV_W-1].res;
    dp          = sat_pack(dv[DIV_W-1].neg, 64'(qr));
    if (dv[DIV_W-1].op == OP_DIV && !dv[DIV_W-1].res.divide_by_zero) begin
      result_next.result_value = dp[WORD_W-1:0];
      result_next.overflow     = dp[WORD_W];
    end
    done_next = dv[DIV_W-1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
    result <= result_next;
  end

  `FPA_ASSERT_DELAY(a_latency, start && !busy, PIPE_LAT, done)
  `FPA_ASSERT_IMPL(a_dz_no_ov, done && result.divide_by_zero, !result.overflow)
  `FPA_ASSERT_IMPL(a_cmp_zero, done && result.compare_true, result.result_value == '0)
  `FPA_ASSERT_ALWAYS(a_reset_quiet, !($past(rst) === 1'b1 && done === 1'b1))

endmodule

@@ tb/sv/fixed_point_q24_8_alu_test.sv @@
module fixed_point_q24_8_alu_test;
  import fpa_pkg::*;

  // scoreboard: predicts each result from the command and the tolerance in force
  class alu_scoreboard;
    fpa_out_t pending[$];
    int errors = 0;

    // saturate a signed 66-bit value into the word
    function automatic fpa_out_t saturate(logic signed [65:0] v);
      fpa_out_t r;
      r = '0;
      if (v > 66'sd2147483647) begin
        r.result_value = 32'h7fffffff;
        r.overflow = 1'b1;
      end else if (v < -66'sd2147483648) begin
        r.result_value = 32'h80000000;
        r.overflow = 1'b1;
      end else begin
        r.result_value = v[31:0];
      end
      return r;
    endfunction

    function automatic fpa_out_t predict(fpa_in_t c, logic [7:0] tol);
      logic signed [65:0] a, b, d, t, v;
      logic [65:0] ma, mb, p, n, q, rem;
      logic neg, in_band, gt, lt;
      fpa_out_t r;
      a = c.operand_a;
      b = c.operand_b;
      t = {58'd0, tol};
      d = a - b;
      in_band = (d <= t) && (d >= -t);
      gt = !in_band && d > 0;
      lt = !in_band && d < 0;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      neg = (a < 0) != (b < 0);
      r = '0;
      case (c.operation)
        OP_ADD: r = saturate(a + b);
        OP_SUB: r = saturate(d);
        OP_MUL: begin
          // magnitude product, round half away from zero
          p = (ma * mb + 66'd128) >> 8;
          v = neg ? -$signed(p) : $signed(p);
          r = saturate(v);
        end
        OP_DIV: begin
          if (mb <= {58'd0, tol}) begin
            r.result_value = c.operand_a;
            r.divide_by_zero = 1'b1;
          end else begin
            n = ma << 8;
            q = n / mb;
            rem = n % mb;
            if (rem >= mb - rem) q = q + 1;
            v = neg ? -$signed(q) : $signed(q);
            r = saturate(v);
          end
        end
        OP_NEG: r = saturate(-a);
        OP_INC: r = saturate(a + t);
        OP_DEC: r = saturate(a - t);
        OP_EQ: r.compare_true = in_band;
        OP_NE: r.compare_true = !in_band;
        OP_GT: r.compare_true = gt;
        OP_LT: r.compare_true = lt;
        OP_GE: r.compare_true = in_band || gt;
        OP_LE: r.compare_true = in_band || lt;
        OP_MAX: r.result_value = (in_band || gt) ? c.operand_a : c.operand_b;
        OP_MIN: r.result_value = (in_band || lt) ? c.operand_a : c.operand_b;
        default: begin
          p = (ma + 66'd128) >> 8;
          v = (a < 0) ? -$signed(p) : $signed(p);
          r.result_value = v[31:0];
        end
      endcase
      return r;
    endfunction

    function void note_command(fpa_in_t c, logic [7:0] tol);
      pending.push_back(predict(c, tol));
    endfunction

    function void check_result(fpa_out_t got);
      fpa_out_t exp;
      if (pending.size() == 0) begin
        $error("result with no item outstanding: %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.result_value !== exp.result_value) begin
        $error("result_value: expected %h actual %h", exp.result_value, got.result_value);
        errors++;
      end
      if (got.compare_true !== exp.compare_true) begin
        $error("compare_true: expected %b actual %b", exp.compare_true, got.compare_true);
        errors++;
      end
      if (got.divide_by_zero !== exp.divide_by_zero) begin
        $error("divide_by_zero: expected %b actual %b", exp.divide_by_zero,
               got.divide_by_zero);
        errors++;
      end
      if (got.overflow !== exp.overflow) begin
        $error("overflow: expected %b actual %b", exp.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  fpa_in_t cmd = '0;
  logic tolerance_we = 1'b0;
  logic [7:0] tolerance_wdata = 8'd0;
  logic done;
  fpa_out_t result;

  alu_scoreboard sb = new();
  logic [7:0] tol_now = 8'd1;  // tolerance the block holds
  int cycle_count = 0;
  localparam int CYCLE_LIMIT = 400000;

  fixed_point_q24_8_alu i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .tolerance_we(tolerance_we), .tolerance_wdata(tolerance_wdata),
    .done(done), .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // results are sampled at the edge that ends their strobe cycle
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done) sb.check_result(result);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // present one item and hold it until taken
  task automatic send_item(op_t op, logic [31:0] a, logic [31:0] b);
    fpa_in_t c;
    c.operation = op;
    c.operand_a = a;
    c.operand_b = b;
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(c, tol_now);
  endtask

  // drop start after the last item of a burst
  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for every result, then for the pipeline to empty
  task automatic drain();
    idle_cycles(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  // the register is written only with the pipeline empty
  task automatic write_tolerance(logic [7:0] v);
    tolerance_we <= 1'b1;
    tolerance_wdata <= v;
    @(posedge clk);
    tolerance_we <= 1'b0;
    tol_now = v;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
      3: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 300)
                                       : 32'h80000000 + $urandom_range(0, 300);
      4: return 32'($urandom_range(0, 255)) << $urandom_range(0, 20);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [31:0] a, b;
    int burst;
    while (count > 0) begin
      burst = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
      repeat (burst) begin
        a = rand_operand();
        // near-equal pairs exercise the tolerance band
        case ($urandom_range(0, 3))
          0: b = a + 32'($signed($urandom_range(0, 600)) - 300);
          1: b = 32'($signed($urandom_range(0, 600)) - 300);
          default: b = rand_operand();
        endcase
        send_item(op_t'($urandom_range(0, 15)), a, b);
        count--;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every operation at the reset tolerance, extremes and special cases
    for (int op = 0; op < 16; op++) send_item(op_t'(op), 32'h00000380, 32'hfffffe80);
    send_item(OP_NEG, 32'h80000000, 32'h0);
    send_item(OP_ADD, 32'h7fffffff, 32'h7fffffff);
    send_item(OP_SUB, 32'h80000000, 32'h7fffffff);
    send_item(OP_MUL, 32'h80000000, 32'h80000000);
    send_item(OP_MUL, 32'h00000180, 32'hffffff80);
    send_item(OP_DIV, 32'h12345678, 32'hffffffff);
    send_item(OP_DIV, 32'h7fffffff, 32'h00000002);
    send_item(OP_ROUND, 32'hffffff80, 32'h0);
    send_item(OP_EQ, 32'h00000101, 32'h00000100);
    drain();

    // several tolerance settings, extremes included
    write_tolerance(8'd0);
    random_phase(300);
    drain();
    write_tolerance(8'd255);
    send_item(OP_INC, 32'h7fffff80, 32'h0);
    send_item(OP_DEC, 32'h80000010, 32'h0);
    send_item(OP_DIV, 32'h00001000, 32'hffffff01);
    random_phase(500);
    drain();
    write_tolerance(8'hAA);
    random_phase(400);
    drain();
    write_tolerance(8'h55);
    random_phase(400);
    drain();
    write_tolerance(8'd1);
    random_phase(330);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ fixed_point_q24_8_alu.f @@
+incdir+sv
sv/fpa_pkg.sv
sv/fixed_point_q24_8_alu.sv
tb/sv/fixed_point_q24_8_alu_test.sv
